@@ hdl/pll_pkg.sv @@
// Package for the pooled linked list engine: controller states, status codes,
// operation codes and the fixed key widths. Depends on nothing.
`default_nettype none

package pll_pkg;

  localparam int KEY_W     = 64;
  localparam int KEY_BYTES = KEY_W / 8;
  localparam int KB_W      = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_EMIT
  } fsm_state_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_EMPTY,
    STATUS_NOT_FOUND
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

endpackage

`default_nettype wire

@@ hdl/pooled_linked_list_engine.sv @@
// Pooled linked list engine: a node memory {next, key} and a used-bit memory,
// both with registered reads, driven by a small controller.
// Depends on pll_pkg.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid in_ready in_operation in_key          | in
//           | in_key_bytes                                   |
//   result  | out_valid out_ready out_status out_slot        | out
//           | out_entries                                    |
//
// An insert reads the used bits one by one from the free hint until it finds
// a free slot, at most POOL_SLOTS of them; a delete walks the list from the
// head, one node memory read per node visited, up to POOL_SLOTS nodes, and
// ends at a match or at the end of the list.
// After reset a clearing pass writes every used bit with in_ready low.
// A result beat waits in the output register while the next input beat is
// taken; a stalled result holds the engine only when a second result is
// ready.
`default_nettype none

module pooled_linked_list_engine
  import pll_pkg::*;
#(
  parameter int POOL_SLOTS    = 64,
  parameter int KEY_BYTES_MAX = 8,
  localparam int SW = $clog2(POOL_SLOTS),
  localparam int LW = SW + 1,
  localparam int CW = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_operation,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [KB_W-1:0]  in_key_bytes,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [SW-1:0]         out_slot,
  output logic [CW-1:0]         out_entries
);

  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SLOTS - 1);
  localparam logic [CW-1:0] POOL_CNT  = CW'(POOL_SLOTS);
  localparam int            NW        = LW + KEY_W;

  logic [NW-1:0] node_mem [POOL_SLOTS];
  logic          used_mem [POOL_SLOTS];

  fsm_state_t         state_r, state_nxt;
  logic [LW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SW-1:0]      hint_r, hint_nxt;
  logic [SW-1:0]      clr_r, clr_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [KEY_W-1:0]   mask_r, mask_nxt;
  logic [SW-1:0]      chk_r, chk_nxt;
  logic [CW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic [LW-1:0]      cur_r, cur_nxt;
  logic [LW-1:0]      prev_r, prev_nxt;
  logic [KEY_W-1:0]   prev_key_r, prev_key_nxt;
  logic [CW-1:0]      steps_r, steps_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [SW-1:0]      res_slot_r, res_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [SW-1:0]      out_slot_r, out_slot_nxt;
  logic [CW-1:0]      out_entries_r, out_entries_nxt;

  logic               node_re, node_we;
  logic [SW-1:0]      node_raddr, node_waddr;
  logic [NW-1:0]      node_wdata, node_rdata_r;
  logic               used_re, used_we, used_wdata;
  logic [SW-1:0]      used_raddr, used_waddr;
  logic               used_rdata_r;

  logic               accept;
  logic [KB_W-1:0]    kb_sat;
  logic [LW-1:0]      rd_next;
  logic [KEY_W-1:0]   rd_key;
  logic               cur_null, rd_next_null, prev_null, key_match, walk_end;
  logic [SW-1:0]      chk_inc;

  assign rd_next      = node_rdata_r[KEY_W +: LW];
  assign rd_key       = node_rdata_r[KEY_W-1:0];
  assign cur_null     = cur_r >= NULL_LINK;
  assign prev_null    = prev_r >= NULL_LINK;
  assign rd_next_null = rd_next >= NULL_LINK;
  assign key_match    = ((rd_key ^ key_r) & mask_r) == '0;
  assign walk_end     = cur_null || (steps_r == POOL_CNT);
  assign chk_inc      = (chk_r == LAST_SLOT) ? '0 : chk_r + 1'b1;
  assign kb_sat       = (in_key_bytes > KB_W'(KEY_BYTES_MAX)) ? KB_W'(KEY_BYTES_MAX)
                                                              : in_key_bytes;

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rdata_r <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    if (used_re) begin
      used_rdata_r <= used_mem[used_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_SLOT) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_INSERT) begin
            state_nxt = (count_r >= POOL_CNT) ? ST_EMIT : ST_SCAN;
          end else begin
            state_nxt = (count_r == '0) ? ST_EMIT : ST_WALK;
          end
        end
      end
      ST_SCAN: begin
        if (!used_rdata_r || (scan_cnt_r == CW'(POOL_SLOTS - 1))) state_nxt = ST_EMIT;
      end
      ST_WALK: begin
        if (walk_end || key_match) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    accept          = in_valid && in_ready;
    head_nxt        = head_r;
    count_nxt       = count_r;
    hint_nxt        = hint_r;
    clr_nxt         = clr_r;
    key_nxt         = key_r;
    mask_nxt        = mask_r;
    chk_nxt         = chk_r;
    scan_cnt_nxt    = scan_cnt_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    prev_key_nxt    = prev_key_r;
    steps_nxt       = steps_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_entries_nxt = out_entries_r;
    node_re         = 1'b0;
    node_raddr      = cur_r[SW-1:0];
    node_we         = 1'b0;
    node_waddr      = chk_r;
    node_wdata      = {head_r, key_r};
    used_re         = 1'b0;
    used_raddr      = chk_inc;
    used_we         = 1'b0;
    used_waddr      = chk_r;
    used_wdata      = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_r;
        used_wdata = 1'b0;
        clr_nxt    = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          key_nxt      = in_key;
          chk_nxt      = hint_r;
          scan_cnt_nxt = '0;
          cur_nxt      = head_r;
          prev_nxt     = NULL_LINK;
          steps_nxt    = '0;
          res_slot_nxt = '0;
          for (int b = 0; b < KEY_BYTES; b++) begin
            mask_nxt[8*b +: 8] = {8{KB_W'(b) < kb_sat}};
          end
          if (in_operation == OP_INSERT) begin
            res_status_nxt = STATUS_FULL;
            used_re        = (count_r < POOL_CNT);
            used_raddr     = hint_r;
          end else begin
            res_status_nxt = (count_r == '0) ? STATUS_EMPTY : STATUS_NOT_FOUND;
            node_re        = (count_r != '0) && (head_r < NULL_LINK);
            node_raddr     = head_r[SW-1:0];
          end
        end
      end
      ST_SCAN: begin
        if (!used_rdata_r) begin
          used_we        = 1'b1;
          node_we        = 1'b1;
          head_nxt       = {1'b0, chk_r};
          count_nxt      = count_r + 1'b1;
          hint_nxt       = chk_inc;
          res_status_nxt = STATUS_OK;
          res_slot_nxt   = chk_r;
        end else begin
          used_re      = 1'b1;
          chk_nxt      = chk_inc;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ST_WALK: begin
        if (!walk_end) begin
          if (key_match) begin
            if (prev_null) begin
              head_nxt = rd_next;
            end else begin
              node_we    = 1'b1;
              node_waddr = prev_r[SW-1:0];
              node_wdata = {rd_next, prev_key_r};
            end
            used_we        = 1'b1;
            used_waddr     = cur_r[SW-1:0];
            used_wdata     = 1'b0;
            count_nxt      = count_r - 1'b1;
            hint_nxt       = cur_r[SW-1:0];
            res_status_nxt = STATUS_OK;
            res_slot_nxt   = cur_r[SW-1:0];
          end else begin
            prev_nxt     = cur_r;
            prev_key_nxt = rd_key;
            cur_nxt      = rd_next;
            steps_nxt    = steps_r + 1'b1;
            node_re      = !rd_next_null;
            node_raddr   = rd_next[SW-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_slot_nxt    = res_slot_r;
          out_entries_nxt = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= NULL_LINK;
      count_r     <= '0;
      hint_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      hint_r      <= hint_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    mask_r        <= mask_nxt;
    chk_r         <= chk_nxt;
    scan_cnt_r    <= scan_cnt_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    prev_key_r    <= prev_key_nxt;
    steps_r       <= steps_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_slot    = out_slot_r;
  assign out_entries = out_entries_r;

  // The list is empty exactly when the head link is null.
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (head_r >= NULL_LINK))
    else $error("head link and node count disagree");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= POOL_CNT)
    else $error("node count beyond pool size");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("result beat raised outside the emit state");

  a_clear_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!node_we && !out_valid_r))
    else $error("activity during the clearing pass");

endmodule

`default_nettype wire
